// ===== rtl/core/bmprgb_pkg.sv =====
// Shared constants, types and helper functions for the bitmap-to-RGB565 converter.
package bmprgb_pkg;

   localparam int DIM_W         = 13;
   localparam int MAX_DIMENSION = 4096;
   localparam int BYTE_W        = 8;
   localparam int ROW_BYTE_W    = 15;
   localparam int INDEX_W       = 24;
   localparam int PIXEL_W       = 16;
   localparam int ASM_W         = 24;
   localparam int CSR_INDEX_W   = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DISPLAY_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DISPLAY_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_FORMAT   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TOP_DOWN       = 3'd5;

   // Source pixel formats; the unused code behaves as 32-bit.
   localparam logic [1:0] FMT_16 = 2'd0;
   localparam logic [1:0] FMT_24 = 2'd1;
   localparam logic [1:0] FMT_32 = 2'd2;

   typedef struct packed {
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] clip_width;
      logic [DIM_W-1:0] clip_height;
      logic [1:0]       pixel_format;
      logic             top_down;
   } cfg_type;

   typedef struct packed {
      logic [DIM_W-1:0]   row;
      logic [DIM_W-1:0]   col;
      logic [PIXEL_W-1:0] pixel;
      logic               last;
   } pix_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIMENSION)) begin
         r = DIM_W'(MAX_DIMENSION);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] min_dim(input logic [DIM_W-1:0] a,
                                                input logic [DIM_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   // Truncate blue, green and red (low to high byte) to 5:6:5.
   function automatic logic [PIXEL_W-1:0] to_rgb565(input logic [ASM_W-1:0] c);
      return {c[23:19], c[15:10], c[7:3]};
   endfunction

endpackage

// ===== rtl/core/bmprgb_decode.sv =====
// Stream state for the bitmap byte stream: pixel assembly, row position and clipping.
module bmprgb_decode (
   input  logic                            clock,
   input  logic                            reset,
   input  bmprgb_pkg::cfg_type             cfg,
   input  logic                            accept,
   input  logic [bmprgb_pkg::BYTE_W-1:0]   pixel_byte,
   output logic                            emit,
   output bmprgb_pkg::pix_type             pix
);

   logic [bmprgb_pkg::ASM_W-1:0]      assembly_ff;
   logic [1:0]                        byte_in_pixel_ff;
   logic [bmprgb_pkg::ROW_BYTE_W-1:0] byte_in_row_ff;
   logic [1:0]                        rem3_ff;
   logic [bmprgb_pkg::DIM_W-1:0]      quo3_ff;
   logic [bmprgb_pkg::DIM_W-1:0]      row_count_ff;
   logic                              image_done_ff;

   logic [bmprgb_pkg::ASM_W-1:0]      asm_base;
   logic [bmprgb_pkg::ASM_W-1:0]      asm_in;
   logic [1:0]                        last_pos;
   logic [bmprgb_pkg::ROW_BYTE_W-1:0] stride_raw;
   logic [bmprgb_pkg::ROW_BYTE_W-1:0] stride_sum;
   logic [bmprgb_pkg::ROW_BYTE_W-1:0] stride;
   logic [bmprgb_pkg::DIM_W:0]        col;
   logic                              stop;
   logic                              pix_end;
   logic                              row_end;
   logic                              visible;
   logic [bmprgb_pkg::DIM_W-1:0]      row_count_inc;
   logic [bmprgb_pkg::ROW_BYTE_W-1:0] byte_in_row_inc;

   assign stop = image_done_ff || (row_count_ff >= cfg.clip_height);

   always_comb begin
      unique case (cfg.pixel_format)
         bmprgb_pkg::FMT_16: begin
            last_pos   = 2'd1;
            stride_raw = {1'b0, cfg.image_width, 1'b0};
            col        = byte_in_row_ff[bmprgb_pkg::ROW_BYTE_W-1:1];
         end
         bmprgb_pkg::FMT_24: begin
            last_pos   = 2'd2;
            stride_raw = {2'b00, cfg.image_width} + {1'b0, cfg.image_width, 1'b0};
            col        = {1'b0, quo3_ff};
         end
         default: begin
            last_pos   = 2'd3;
            stride_raw = {cfg.image_width, 2'b00};
            col        = {1'b0, byte_in_row_ff[bmprgb_pkg::ROW_BYTE_W-1:2]};
         end
      endcase
   end

   // Stored rows are padded to a whole number of 4-byte words.
   assign stride_sum = stride_raw + bmprgb_pkg::ROW_BYTE_W'(3);
   assign stride     = {stride_sum[bmprgb_pkg::ROW_BYTE_W-1:2], 2'b00};

   assign asm_base = (byte_in_pixel_ff == 2'd0) ? '0 : assembly_ff;

   always_comb begin
      unique case (byte_in_pixel_ff)
         2'd0:    asm_in = {16'h0000, pixel_byte};
         2'd1:    asm_in = {asm_base[23:16], pixel_byte, asm_base[7:0]};
         2'd2:    asm_in = {pixel_byte, asm_base[15:0]};
         default: asm_in = asm_base;
      endcase
   end

   assign pix_end         = byte_in_pixel_ff >= last_pos;
   assign byte_in_row_inc = byte_in_row_ff + bmprgb_pkg::ROW_BYTE_W'(1);
   assign row_end         = ({1'b0, byte_in_row_ff} + 16'd1) >= {1'b0, stride};
   assign visible         = col < {1'b0, cfg.clip_width};
   assign row_count_inc   = row_count_ff + bmprgb_pkg::DIM_W'(1);

   assign emit = accept && !stop && pix_end && visible;

   always_comb begin
      pix.row   = cfg.top_down ? row_count_ff
                               : cfg.clip_height - bmprgb_pkg::DIM_W'(1) - row_count_ff;
      pix.col   = col[bmprgb_pkg::DIM_W-1:0];
      pix.pixel = (cfg.pixel_format == bmprgb_pkg::FMT_16) ? asm_in[15:0]
                                                           : bmprgb_pkg::to_rgb565(asm_in);
      pix.last  = (row_count_ff == cfg.clip_height - bmprgb_pkg::DIM_W'(1)) &&
                  (col == {1'b0, cfg.clip_width - bmprgb_pkg::DIM_W'(1)});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         assembly_ff      <= '0;
         byte_in_pixel_ff <= '0;
         byte_in_row_ff   <= '0;
         rem3_ff          <= '0;
         quo3_ff          <= '0;
         row_count_ff     <= '0;
         image_done_ff    <= 1'b0;
      end else if (accept) begin
         if (stop) begin
            image_done_ff <= 1'b1;
         end else begin
            assembly_ff <= asm_in;
            if (row_end) begin
               byte_in_row_ff   <= '0;
               byte_in_pixel_ff <= '0;
               rem3_ff          <= '0;
               quo3_ff          <= '0;
               row_count_ff     <= row_count_inc;
               image_done_ff    <= row_count_inc >= cfg.clip_height;
            end else begin
               byte_in_row_ff   <= byte_in_row_inc;
               byte_in_pixel_ff <= pix_end ? 2'd0 : byte_in_pixel_ff + 2'd1;
               // Running quotient and remainder of the row byte count by three.
               if (rem3_ff == 2'd2) begin
                  rem3_ff <= 2'd0;
                  quo3_ff <= quo3_ff + bmprgb_pkg::DIM_W'(1);
               end else begin
                  rem3_ff <= rem3_ff + 2'd1;
               end
            end
         end
      end
   end

endmodule

// ===== rtl/core/bmp_rows_to_rgb565_framebuffer_top.sv =====
// Top level: configuration registers, byte decoder, index multiply and result register.
// A byte that completes a visible pixel is held in the middle stage, then in the result register.
// Throughput: one byte per cycle while req_ready is high; the pixel index multiply sits in its own stage.
// A result waiting on rsp_ready does not stop the next byte while the middle stage is free.
// Reset restores the configuration registers, clears both valid flags and restarts the stream.
// There is no clearing pass; the block is ready in the cycle after reset falls.
module bmp_rows_to_rgb565_framebuffer_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bmprgb_pkg::BYTE_W-1:0]         req_pixel_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [bmprgb_pkg::INDEX_W-1:0]        rsp_fb_index,
   output logic [bmprgb_pkg::PIXEL_W-1:0]        rsp_pixel_rgb565,
   output logic                                  rsp_last_pixel,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bmprgb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bmprgb_pkg::DIM_W-1:0]          csr_data
);

   logic [bmprgb_pkg::DIM_W-1:0]   image_width_ff;
   logic [bmprgb_pkg::DIM_W-1:0]   image_height_ff;
   logic [bmprgb_pkg::DIM_W-1:0]   display_width_ff;
   logic [bmprgb_pkg::DIM_W-1:0]   display_height_ff;
   logic [1:0]                     pixel_format_ff;
   logic                           top_down_ff;

   bmprgb_pkg::cfg_type            cfg;
   logic [bmprgb_pkg::DIM_W-1:0]   dw;

   logic                           in_fire;
   logic                           emit;
   bmprgb_pkg::pix_type            pix;

   logic                           s1_valid_ff;
   logic                           s1_valid_in;
   bmprgb_pkg::pix_type            s1_word_ff;
   logic                           s1_advance;

   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [bmprgb_pkg::INDEX_W-1:0] rsp_fb_index_ff;
   logic [bmprgb_pkg::PIXEL_W-1:0] rsp_pixel_ff;
   logic                           rsp_last_ff;
   logic [2*bmprgb_pkg::DIM_W-1:0] row_offset;
   logic [2*bmprgb_pkg::DIM_W-1:0] index_sum;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= bmprgb_pkg::DIM_W'(1);
         image_height_ff   <= bmprgb_pkg::DIM_W'(1);
         display_width_ff  <= bmprgb_pkg::DIM_W'(1);
         display_height_ff <= bmprgb_pkg::DIM_W'(1);
         pixel_format_ff   <= bmprgb_pkg::FMT_16;
         top_down_ff       <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            bmprgb_pkg::REG_IMAGE_WIDTH:    image_width_ff    <= csr_data;
            bmprgb_pkg::REG_IMAGE_HEIGHT:   image_height_ff   <= csr_data;
            bmprgb_pkg::REG_DISPLAY_WIDTH:  display_width_ff  <= csr_data;
            bmprgb_pkg::REG_DISPLAY_HEIGHT: display_height_ff <= csr_data;
            bmprgb_pkg::REG_PIXEL_FORMAT:   pixel_format_ff   <= csr_data[1:0];
            bmprgb_pkg::REG_TOP_DOWN:       top_down_ff       <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.image_width  = bmprgb_pkg::clamp_dim(image_width_ff);
      dw               = bmprgb_pkg::clamp_dim(display_width_ff);
      cfg.clip_width   = bmprgb_pkg::min_dim(cfg.image_width, dw);
      cfg.clip_height  = bmprgb_pkg::min_dim(bmprgb_pkg::clamp_dim(image_height_ff),
                                             bmprgb_pkg::clamp_dim(display_height_ff));
      cfg.pixel_format = pixel_format_ff;
      cfg.top_down     = top_down_ff;
   end

   // The middle stage moves on whenever the result register is empty or being emptied.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign in_fire    = req_valid && req_ready;

   bmprgb_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (in_fire),
      .pixel_byte (req_pixel_byte),
      .emit       (emit),
      .pix        (pix)
   );

   assign s1_valid_in  = emit ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign row_offset = {{bmprgb_pkg::DIM_W{1'b0}}, s1_word_ff.row} *
                       {{bmprgb_pkg::DIM_W{1'b0}}, dw};
   assign index_sum  = row_offset + {{bmprgb_pkg::DIM_W{1'b0}}, s1_word_ff.col};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         s1_word_ff <= pix;
      end
      if (s1_advance) begin
         rsp_fb_index_ff <= index_sum[bmprgb_pkg::INDEX_W-1:0];
         rsp_pixel_ff    <= s1_word_ff.pixel;
         rsp_last_ff     <= s1_word_ff.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fb_index     = rsp_fb_index_ff;
   assign rsp_pixel_rgb565 = rsp_pixel_ff;
   assign rsp_last_pixel   = rsp_last_ff;

endmodule
